// ===== rtl/bdc_pkg.sv =====
// ----------------------------------------------------------------------------
// bdc_pkg
// Shared types, register indexes and reset values for the button debounce
// block with long-press repeat and multi-click grouping.
// ----------------------------------------------------------------------------
`default_nettype none

package bdc_pkg;

  localparam int TIME_WIDTH_DEF = 32;
  localparam int CFG_WIDTH      = 16;
  localparam int CFG_IDX_WIDTH  = 4;
  localparam int LONG_WIDTH     = 16;
  localparam int CLICK_WIDTH    = 8;

  // Register indexes on the configuration port
  localparam logic [CFG_IDX_WIDTH-1:0] REG_SETTLE_TIME     = 4'd0;
  localparam logic [CFG_IDX_WIDTH-1:0] REG_LONG_THRESHOLD  = 4'd1;
  localparam logic [CFG_IDX_WIDTH-1:0] REG_REPEAT_INTERVAL = 4'd2;
  localparam logic [CFG_IDX_WIDTH-1:0] REG_CLICK_GAP       = 4'd3;

  // Register reset values, in ms
  localparam logic [CFG_WIDTH-1:0] RST_SETTLE_TIME     = 16'd10;
  localparam logic [CFG_WIDTH-1:0] RST_LONG_THRESHOLD  = 16'd1000;
  localparam logic [CFG_WIDTH-1:0] RST_REPEAT_INTERVAL = 16'd100;
  localparam logic [CFG_WIDTH-1:0] RST_CLICK_GAP       = 16'd200;

  localparam logic [LONG_WIDTH-1:0]  LONG_MAX  = '1;
  localparam logic [CLICK_WIDTH-1:0] CLICK_MAX = '1;

  typedef struct packed {
    logic [CFG_WIDTH-1:0] settle_time;
    logic [CFG_WIDTH-1:0] long_threshold;
    logic [CFG_WIDTH-1:0] repeat_interval;
    logic [CFG_WIDTH-1:0] click_gap;
  } bdc_cfg_t;

  typedef struct packed {
    logic                   stable_level;
    logic                   press_event;
    logic                   release_event;
    logic                   long_event;
    logic [LONG_WIDTH-1:0]  long_count;
    logic                   click_event;
    logic [CLICK_WIDTH-1:0] click_total;
  } bdc_result_t;

endpackage

`default_nettype wire

// ===== rtl/bdc_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// bdc_cfg_regs
// Configuration register file: four 16-bit timing registers.
// ----------------------------------------------------------------------------
`default_nettype none

module bdc_cfg_regs (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              wr_en,
  input  wire logic [bdc_pkg::CFG_IDX_WIDTH-1:0] wr_index,
  input  wire logic [bdc_pkg::CFG_WIDTH-1:0]     wr_data,
  output bdc_pkg::bdc_cfg_t                      cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.settle_time     <= bdc_pkg::RST_SETTLE_TIME;
      cfg.long_threshold  <= bdc_pkg::RST_LONG_THRESHOLD;
      cfg.repeat_interval <= bdc_pkg::RST_REPEAT_INTERVAL;
      cfg.click_gap       <= bdc_pkg::RST_CLICK_GAP;
    end else if (wr_en) begin
      case (wr_index)
        bdc_pkg::REG_SETTLE_TIME:     cfg.settle_time     <= wr_data;
        bdc_pkg::REG_LONG_THRESHOLD:  cfg.long_threshold  <= wr_data;
        bdc_pkg::REG_REPEAT_INTERVAL: cfg.repeat_interval <= wr_data;
        bdc_pkg::REG_CLICK_GAP:       cfg.click_gap       <= wr_data;
        default: ; // drop writes to unknown indexes
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== rtl/bdc_core.sv =====
// ----------------------------------------------------------------------------
// bdc_core
// Per-poll state update: debounce, long-press repeat and click grouping.
// ----------------------------------------------------------------------------
`default_nettype none

module bdc_core #(
  parameter int TIME_WIDTH = bdc_pkg::TIME_WIDTH_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  fire,
  input  wire logic                  raw,
  input  wire logic [TIME_WIDTH-1:0] now,
  input  wire bdc_pkg::bdc_cfg_t     cfg,
  output bdc_pkg::bdc_result_t       result
);

  logic                            level_reg,     level_reg_next;
  logic                            pending_flag,  pending_flag_next;
  logic [TIME_WIDTH-1:0]           pending_start, pending_start_next;
  logic [TIME_WIDTH-1:0]           press_time,    press_time_next;
  logic [TIME_WIDTH-1:0]           release_time,  release_time_next;
  logic [TIME_WIDTH-1:0]           repeat_time,   repeat_time_next;
  logic [bdc_pkg::LONG_WIDTH-1:0]  long_ticks,    long_ticks_next;
  logic [bdc_pkg::CLICK_WIDTH-1:0] click_count,   click_count_next;

  logic [TIME_WIDTH-1:0] settle_w, thresh_w, repeat_w, gap_w;
  logic [TIME_WIDTH-1:0] since_pending, since_press, since_repeat, since_release;

  assign settle_w = TIME_WIDTH'(cfg.settle_time);
  assign thresh_w = TIME_WIDTH'(cfg.long_threshold);
  assign repeat_w = TIME_WIDTH'(cfg.repeat_interval);
  assign gap_w    = TIME_WIDTH'(cfg.click_gap);

  // Elapsed times wrap modulo 2^TIME_WIDTH
  assign since_pending = now - pending_start;
  assign since_repeat  = now - repeat_time;
  assign since_release = now - release_time;
  assign since_press   = now - press_time;

  always_comb begin
    level_reg_next     = level_reg;
    pending_flag_next  = pending_flag;
    pending_start_next = pending_start;
    press_time_next    = press_time;
    release_time_next  = release_time;
    repeat_time_next   = repeat_time;
    long_ticks_next    = long_ticks;
    click_count_next   = click_count;
    result             = '0;

    // Debounce
    if (pending_flag) begin
      if (since_pending >= settle_w) begin
        if (raw != level_reg) begin
          if (raw) begin
            press_time_next      = now;
            result.press_event   = 1'b1;
          end else begin
            release_time_next    = now;
            result.release_event = 1'b1;
            long_ticks_next      = '0;
            if (since_press < thresh_w) begin
              if (click_count != bdc_pkg::CLICK_MAX) begin
                click_count_next = click_count + 1'b1;
              end
            end else begin
              click_count_next = '0;
            end
          end
        end
        level_reg_next    = raw;
        pending_flag_next = 1'b0;
      end
    end else if (raw != level_reg) begin
      pending_flag_next  = 1'b1;
      pending_start_next = now;
    end

    // Long press; a fresh press this poll is excluded explicitly, so it cannot fire
    if (level_reg_next) begin
      if (long_ticks_next == '0) begin
        if (press_time_next != '0 && !result.press_event && since_press > thresh_w) begin
          long_ticks_next   = bdc_pkg::LONG_WIDTH'(1);
          repeat_time_next  = now;
          result.long_event = 1'b1;
          result.long_count = bdc_pkg::LONG_WIDTH'(1);
        end
      end else if (since_repeat > repeat_w) begin
        repeat_time_next = now;
        if (long_ticks_next != bdc_pkg::LONG_MAX) begin
          long_ticks_next = long_ticks_next + 1'b1;
        end
        result.long_event = 1'b1;
        result.long_count = long_ticks_next;
      end
    end

    // Click group report; a release this poll is excluded explicitly
    if (click_count_next != '0 && !level_reg_next && !result.release_event &&
        since_release > gap_w) begin
      result.click_event = 1'b1;
      result.click_total = click_count_next;
      click_count_next   = '0;
    end

    result.stable_level = level_reg_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      level_reg     <= 1'b0;
      pending_flag  <= 1'b0;
      pending_start <= '0;
      press_time    <= '0;
      release_time  <= '0;
      repeat_time   <= '0;
      long_ticks    <= '0;
      click_count   <= '0;
    end else if (fire) begin
      level_reg     <= level_reg_next;
      pending_flag  <= pending_flag_next;
      pending_start <= pending_start_next;
      press_time    <= press_time_next;
      release_time  <= release_time_next;
      repeat_time   <= repeat_time_next;
      long_ticks    <= long_ticks_next;
      click_count   <= click_count_next;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/button_debounce_click_longpress_top.sv =====
// ----------------------------------------------------------------------------
// button_debounce_click_longpress_top
// Button poll processor: debounce, long-press repeat and multi-click events.
// ----------------------------------------------------------------------------
// Path: input transfer to result transfer through the input register, then the
//   result register, one result per poll.
// Throughput: one poll per cycle unless out_ready stalls; bdc_core's single pass sets it.
// Reset: rst (synchronous) empties both registers, clears all state and
//   loads the register defaults 10, 1000, 100, 200 ms.
`default_nettype none

module button_debounce_click_longpress_top #(
  parameter int TIME_WIDTH = bdc_pkg::TIME_WIDTH_DEF
) (
  input  wire logic                               clk,
  input  wire logic                               rst,
  // poll input
  input  wire logic                               in_valid,
  output logic                                    in_ready,
  input  wire logic                               raw_level,
  input  wire logic [TIME_WIDTH-1:0]              now_ms,
  // configuration writes
  input  wire logic                               cfg_valid,
  output logic                                    cfg_ready,
  input  wire logic [bdc_pkg::CFG_IDX_WIDTH-1:0]  cfg_index,
  input  wire logic [bdc_pkg::CFG_WIDTH-1:0]      cfg_data,
  // result output
  output logic                                    out_valid,
  input  wire logic                               out_ready,
  output logic                                    stable_level,
  output logic                                    press_event,
  output logic                                    release_event,
  output logic                                    long_event,
  output logic [bdc_pkg::LONG_WIDTH-1:0]          long_count,
  output logic                                    click_event,
  output logic [bdc_pkg::CLICK_WIDTH-1:0]         click_total
);

  bdc_pkg::bdc_cfg_t    cfg;
  bdc_pkg::bdc_result_t core_result;
  bdc_pkg::bdc_result_t out_reg;

  logic                  poll_valid;
  logic                  poll_raw;
  logic [TIME_WIDTH-1:0] poll_now;
  logic                  fire;

  // Writes must come only while idle; the block does not enforce it and always takes them
  assign cfg_ready = 1'b1;

  bdc_cfg_regs u_cfg (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (cfg_valid),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .cfg      (cfg)
  );

  // Advance the held poll whenever the result register is free or draining
  assign fire     = poll_valid && (!out_valid || out_ready);
  assign in_ready = !poll_valid || fire;

  always_ff @(posedge clk) begin
    if (rst) begin
      poll_valid <= 1'b0;
    end else if (in_ready) begin
      poll_valid <= in_valid;
    end
  end

  // Capture the payload on every input transfer
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      poll_raw <= raw_level;
      poll_now <= now_ms;
    end
  end

  bdc_core #(
    .TIME_WIDTH (TIME_WIDTH)
  ) u_core (
    .clk    (clk),
    .rst    (rst),
    .fire   (fire),
    .raw    (poll_raw),
    .now    (poll_now),
    .cfg    (cfg),
    .result (core_result)
  );

  // Result register: load on advance, drop valid once transferred
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (fire) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_reg <= core_result;
    end
  end

  assign stable_level  = out_reg.stable_level;
  assign press_event   = out_reg.press_event;
  assign release_event = out_reg.release_event;
  assign long_event    = out_reg.long_event;
  assign long_count    = out_reg.long_count;
  assign click_event   = out_reg.click_event;
  assign click_total   = out_reg.click_total;

endmodule

`default_nettype wire

// ===== rtl/bdc_checker.sv =====
// ----------------------------------------------------------------------------
// bdc_checker
// Port-level checks on result consistency, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module bdc_checker #(
  parameter int TIME_WIDTH = bdc_pkg::TIME_WIDTH_DEF
) (
  input wire logic                              clk,
  input wire logic                              rst,
  input wire logic                              in_valid,
  input wire logic                              in_ready,
  input wire logic                              raw_level,
  input wire logic [TIME_WIDTH-1:0]             now_ms,
  input wire logic                              out_valid,
  input wire logic                              out_ready,
  input wire logic                              stable_level,
  input wire logic                              press_event,
  input wire logic                              release_event,
  input wire logic                              long_event,
  input wire logic [bdc_pkg::LONG_WIDTH-1:0]    long_count,
  input wire logic                              click_event,
  input wire logic [bdc_pkg::CLICK_WIDTH-1:0]   click_total
);

  // A waiting poll holds
  a_in_hold: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_ready |=> in_valid && $stable(raw_level) && $stable(now_ms))
    else $error("poll changed while waiting");

  // A stalled result holds its valid, level, counts and long flag
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(stable_level) &&
      $stable(long_count) && $stable(click_total) && $stable(long_event))
    else $error("result changed while stalled");

  // Press and release agree with the debounced level
  a_edge_level: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(press_event && release_event) &&
      (!press_event || stable_level) && (!release_event || !stable_level))
    else $error("press/release inconsistent with level");

  // Long events only while held, with a nonzero count, count zero otherwise
  a_long: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (long_event ? (stable_level && long_count != 0) : (long_count == 0)))
    else $error("long event fields inconsistent");

  // Click groups only while released, with a nonzero total
  a_click: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (click_event ? (!stable_level && click_total != 0) : (click_total == 0)))
    else $error("click event fields inconsistent");

endmodule

bind button_debounce_click_longpress_top bdc_checker #(
  .TIME_WIDTH (TIME_WIDTH)
) u_bdc_checker (.*);

`default_nettype wire

// ===== tb/tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb - button debounce, long-press and multi-click testbench
// Polls the block with raw button levels and millisecond times shaped as
// bounces, click groups, long holds, time jumps and wraparounds. A tracker
// class mirrors the debounce, long-press and click logic and compares every
// result transfer against its oldest expected event set.
// ----------------------------------------------------------------------------

module tb;
  import bdc_pkg::*;

  localparam int TW            = TIME_WIDTH_DEF;
  localparam int CYCLE_LIMIT   = 1000000;
  localparam int DRAIN_CYCLES  = 6;     // slack after the last owed result
  localparam int HOLD_OFF      = 300;   // long receiver stall, in cycles
  localparam int IDX_SPARE_LO  = REG_CLICK_GAP + 1;
  localparam int IDX_SPARE_HI  = (1 << CFG_IDX_WIDTH) - 1;
  localparam int BOUNCE_PCT    = 8;
  localparam int PHASE_POLLS   = 90;

  // --------------------------------------------------------------------------
  // Event tracker: its own copy of the registers and the button state, and
  // the queue of results still owed by the block.
  // --------------------------------------------------------------------------
  class button_event_tracker;
    bit [CFG_WIDTH-1:0]   settle, long_thr, rep_int, gap;
    bit                   level, pending;
    bit [TW-1:0]          pend_start, press_t, release_t, repeat_t;
    bit [LONG_WIDTH-1:0]  long_n;
    bit [CLICK_WIDTH-1:0] clicks;
    bdc_result_t          due_events[$];
    int                   failures;
    int                   results_seen;

    function new();
      settle    = RST_SETTLE_TIME;
      long_thr  = RST_LONG_THRESHOLD;
      rep_int   = RST_REPEAT_INTERVAL;
      gap       = RST_CLICK_GAP;
      level     = 1'b0;
      pending   = 1'b0;
      pend_start = '0;
      press_t   = '0;
      release_t = '0;
      repeat_t  = '0;
      long_n    = '0;
      clicks    = '0;
      failures  = 0;
      results_seen = 0;
    endfunction

    function bit [TW-1:0] span(bit [TW-1:0] later, bit [TW-1:0] earlier);
      return later - earlier;
    endfunction

    function void write_reg(logic [CFG_IDX_WIDTH-1:0] idx, logic [CFG_WIDTH-1:0] val);
      case (idx)
        REG_SETTLE_TIME:     settle   = val;
        REG_LONG_THRESHOLD:  long_thr = val;
        REG_REPEAT_INTERVAL: rep_int  = val;
        REG_CLICK_GAP:       gap      = val;
        default: ;
      endcase
    endfunction

    // One poll in, one event set out.
    function void take_poll(bit raw, bit [TW-1:0] now);
      bdc_result_t ev;
      ev = '0;
      if (pending) begin
        if (span(now, pend_start) >= settle) begin
          if (raw != level) begin
            if (raw) begin
              press_t = now;
              ev.press_event = 1'b1;
            end else begin
              release_t = now;
              ev.release_event = 1'b1;
              long_n = '0;
              if (span(release_t, press_t) < long_thr) begin
                if (clicks != CLICK_MAX) clicks++;
              end else begin
                clicks = '0;
              end
            end
          end
          level   = raw;
          pending = 1'b0;
        end
      end else if (raw != level) begin
        pending    = 1'b1;
        pend_start = now;
      end

      if (level) begin
        if (long_n == 0) begin
          // a press stamped at time zero never earns a first long event
          if (press_t != 0 && span(now, press_t) > long_thr) begin
            long_n   = LONG_WIDTH'(1);
            repeat_t = now;
            ev.long_event = 1'b1;
            ev.long_count = long_n;
          end
        end else if (span(now, repeat_t) > rep_int) begin
          repeat_t = now;
          if (long_n != LONG_MAX) long_n++;
          ev.long_event = 1'b1;
          ev.long_count = long_n;
        end
      end

      if (clicks != 0 && !level && span(now, release_t) > gap) begin
        ev.click_event = 1'b1;
        ev.click_total = clicks;
        clicks = '0;
      end

      ev.stable_level = level;
      due_events.push_back(ev);
    endfunction

    function void report(string msg);
      failures++;
      if (failures <= 10) $display("%s", msg);
    endfunction

    function void compare_result(bdc_result_t got);
      bdc_result_t want;
      results_seen++;
      if (due_events.size() == 0) begin
        report($sformatf("result %0d arrived with nothing outstanding", results_seen));
        return;
      end
      want = due_events.pop_front();
      if (got.stable_level !== want.stable_level || got.press_event !== want.press_event ||
          got.release_event !== want.release_event || got.long_event !== want.long_event ||
          got.long_count !== want.long_count || got.click_event !== want.click_event ||
          got.click_total !== want.click_total)
        report($sformatf({"result %0d mismatch: exp lvl=%0d prs=%0d rel=%0d long=%0d/%0d ",
                          "click=%0d/%0d, got lvl=%0d prs=%0d rel=%0d long=%0d/%0d ",
                          "click=%0d/%0d"},
                         results_seen, want.stable_level, want.press_event,
                         want.release_event, want.long_event, want.long_count,
                         want.click_event, want.click_total, got.stable_level,
                         got.press_event, got.release_event, got.long_event,
                         got.long_count, got.click_event, got.click_total));
    endfunction

    function int outstanding();
      return due_events.size();
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // DUT hookup. Every input starts at a known value.
  // --------------------------------------------------------------------------
  logic                     clk = 1'b0;
  logic                     rst = 1'b1;
  logic                     in_valid = 1'b0;
  logic                     in_ready;
  logic                     raw_level = 1'b0;
  logic [TW-1:0]            now_ms = '0;
  logic                     cfg_valid = 1'b0;
  logic                     cfg_ready;
  logic [CFG_IDX_WIDTH-1:0] cfg_index = '0;
  logic [CFG_WIDTH-1:0]     cfg_data = '0;
  logic                     out_valid;
  logic                     out_ready = 1'b0;
  logic                     stable_level, press_event, release_event, long_event;
  logic [LONG_WIDTH-1:0]    long_count;
  logic                     click_event;
  logic [CLICK_WIDTH-1:0]   click_total;

  button_debounce_click_longpress_top dut (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .raw_level     (raw_level),
    .now_ms        (now_ms),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .stable_level  (stable_level),
    .press_event   (press_event),
    .release_event (release_event),
    .long_event    (long_event),
    .long_count    (long_count),
    .click_event   (click_event),
    .click_total   (click_total)
  );

  button_event_tracker tracker = new();

  int          idle_pct  = 0;    // chance per cycle that the sender holds off
  int          stall_pct = 0;    // chance per cycle that the receiver stalls
  int          hold_reqs = 0;    // bumped by the stimulus to ask for a long stall
  int          hold_seen = 0;
  int          hold_left = 0;
  int          cycles    = 0;
  int          polls_sent = 0;
  bit [TW-1:0] ms_clock  = '0;   // running time handed to the block

  always #5 clk = ~clk;

  // Abort a hung run.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // Receiver: random stalls, plus a long hold-off on request so the block
  // fills up and must push back on its input.
  always @(posedge clk) begin
    if (hold_reqs != hold_seen) begin
      hold_seen <= hold_reqs;
      hold_left <= HOLD_OFF;
      out_ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(0, 99) >= stall_pct);
    end
  end

  // Sample the result port at the edge: these are the values the block saw.
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready)
      tracker.compare_result({stable_level, press_event, release_event, long_event,
                              long_count, click_event, click_total});
  end

  // --------------------------------------------------------------------------
  // Drivers. Each task starts and ends on a rising edge.
  // --------------------------------------------------------------------------

  // Offer one poll and hold it until the transfer. Valid stays high when the
  // next poll follows without a gap.
  task automatic send_poll(bit lvl, bit [TW-1:0] t);
    while ($urandom_range(0, 99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid  <= 1'b1;
    raw_level <= lvl;
    now_ms    <= t;
    do @(posedge clk); while (!in_ready);
    tracker.take_poll(lvl, t);
    polls_sent++;
  endtask

  // Advance the clock by dt and poll.
  task automatic tick(bit lvl, int unsigned dt);
    ms_clock += dt;
    send_poll(lvl, ms_clock);
  endtask

  // Write all four registers plus one spare index that must be ignored;
  // the spare goes last so a bad decode would clobber a live register.
  task automatic write_settings(bit [CFG_WIDTH-1:0] s, bit [CFG_WIDTH-1:0] l,
                                bit [CFG_WIDTH-1:0] r, bit [CFG_WIDTH-1:0] g);
    logic [CFG_IDX_WIDTH-1:0] idx [5];
    logic [CFG_WIDTH-1:0]     val [5];
    idx = '{REG_SETTLE_TIME, REG_LONG_THRESHOLD, REG_REPEAT_INTERVAL, REG_CLICK_GAP,
            CFG_IDX_WIDTH'($urandom_range(IDX_SPARE_HI, IDX_SPARE_LO))};
    val = '{s, l, r, g, CFG_WIDTH'($urandom())};
    for (int i = 0; i < 5; i++) begin
      cfg_valid <= 1'b1;
      cfg_index <= idx[i];
      cfg_data  <= val[i];
      do @(posedge clk); while (!cfg_ready);
      tracker.write_reg(idx[i], val[i]);
    end
    cfg_valid <= 1'b0;
  endtask

  // Drop valid, wait for every owed result, then let the pipeline empty.
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (tracker.outstanding() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Step sizes cluster around a config value: just under, on, just over,
  // and some far off, so every compare sees both sides of its boundary.
  function automatic int unsigned pick_step(int unsigned h);
    case ($urandom_range(0, 6))
      0:       return (h == 0) ? 0 : h - 1;
      1:       return h;
      2:       return h + 1;
      3:       return $urandom_range(0, h);
      4:       return h + $urandom_range(1, h + 1);
      5:       return $urandom_range(0, 3);
      default: return $urandom_range(1, 40);
    endcase
  endfunction

  // Hold a level over n polls, with the odd bounce against it.
  task automatic hold_level(bit lvl, int unsigned n, int unsigned h);
    repeat (n) tick(($urandom_range(0, 99) < BOUNCE_PCT) ? ~lvl : lvl, pick_step(h));
  endtask

  // One randomly chosen gesture, scaled to the current register values.
  task automatic random_gesture();
    int unsigned s, l, r, g, press_h, relax_h, sel;
    s = tracker.settle;
    l = tracker.long_thr;
    r = tracker.rep_int;
    g = tracker.gap;
    press_h = (s > l / 3) ? s : l / 3;
    relax_h = (s > g / 3) ? s : g / 3;
    sel = $urandom_range(0, 99);
    if (sel < 50) begin
      // click group: short presses, short releases, then a quiet spell
      repeat ($urandom_range(1, 4)) begin
        hold_level(1'b1, $urandom_range(2, 3), press_h);
        hold_level(1'b0, $urandom_range(2, 3), relax_h);
      end
      hold_level(1'b0, 2, g);
    end else if (sel < 70) begin
      // long hold with repeats
      hold_level(1'b1, 2, s);
      hold_level(1'b1, $urandom_range(2, 5), l / 2 + 1);
      hold_level(1'b1, $urandom_range(2, 8), r);
      hold_level(1'b0, 2, s);
    end else if (sel < 82) begin
      // contact bounce inside the settle window
      repeat ($urandom_range(3, 8)) tick(1'($urandom_range(0, 1)), $urandom_range(0, s));
    end else if (sel < 94) begin
      // arbitrary jumps across the whole time range
      repeat ($urandom_range(1, 3)) tick(1'($urandom_range(0, 1)), $urandom());
    end else begin
      // settle a press exactly at time zero, across the wrap
      hold_level(1'b0, 2, s);
      ms_clock = '0 - TW'(s) - TW'($urandom_range(0, 1)) - 1;
      tick(1'b1, 1);
      tick(1'b1, TW'('0 - ms_clock));
      hold_level(1'b1, $urandom_range(2, 5), l / 2 + 1);
      hold_level(1'b0, 2, s);
    end
  endtask

  // Program, then poll at random until the phase budget is spent.
  task automatic run_phase(bit [CFG_WIDTH-1:0] s, bit [CFG_WIDTH-1:0] l,
                           bit [CFG_WIDTH-1:0] r, bit [CFG_WIDTH-1:0] g,
                           int sender_idle, int receiver_stall, int n_polls,
                           bit squeeze);
    int goal;
    write_settings(s, l, r, g);
    idle_pct  = sender_idle;
    stall_pct = receiver_stall;
    if (squeeze) hold_reqs <= hold_reqs + 1;
    goal = polls_sent + n_polls;
    while (polls_sent < goal) random_gesture();
    wait_idle();
  endtask

  // Drive the click counter into saturation with back-to-back polls, then
  // repeat long events on every poll of a hold.
  task automatic saturate_counters();
    write_settings('0, RST_LONG_THRESHOLD, '0, '1);
    idle_pct  = 0;
    stall_pct = 0;
    tick(1'b0, 1);
    tick(1'b0, 1);
    tick(1'b0, 70000);
    // more short clicks than the click counter can hold
    repeat (int'(CLICK_MAX) + 3) begin
      tick(1'b1, 1);
      tick(1'b1, 1);
      tick(1'b0, 1);
      tick(1'b0, 1);
    end
    tick(1'b0, 70000);
    // hold past the threshold, then repeat on every poll
    tick(1'b1, 1);
    tick(1'b1, 1);
    tick(1'b1, RST_LONG_THRESHOLD + 1);
    repeat (20) tick(1'b1, 1);
    tick(1'b0, 1);
    tick(1'b0, 1);
    wait_idle();
  endtask

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // Directed polls under the reset register values.
    // Press settles exactly on the window boundary and lands at time zero,
    // so the long hold that follows must stay silent.
    send_poll(1'b1, 32'hFFFF_FFF6);
    send_poll(1'b1, 32'h0000_0000);
    send_poll(1'b1, 32'd2000);
    send_poll(1'b0, 32'd2001);
    send_poll(1'b0, 32'd2011);
    // long press: threshold edge, first event, repeat edge, repeat
    send_poll(1'b1, 32'd2100);
    send_poll(1'b1, 32'd2110);
    send_poll(1'b1, 32'd3110);
    send_poll(1'b1, 32'd3111);
    send_poll(1'b1, 32'd3211);
    send_poll(1'b1, 32'd3212);
    send_poll(1'b0, 32'd3300);
    send_poll(1'b0, 32'd3310);
    // short click, then the gap boundary and the group report
    send_poll(1'b1, 32'd3400);
    send_poll(1'b1, 32'd3410);
    send_poll(1'b0, 32'd3500);
    send_poll(1'b0, 32'd3510);
    send_poll(1'b0, 32'd3710);
    send_poll(1'b0, 32'd3711);
    // bounce that settles back to the old level
    send_poll(1'b1, 32'd3720);
    send_poll(1'b0, 32'd3725);
    send_poll(1'b0, 32'd3730);
    // top of the time range
    send_poll(1'b1, 32'hFFFF_FFFF);
    send_poll(1'b1, 32'hFFFF_FFFF);
    ms_clock = 32'hFFFF_FFFF;
    wait_idle();

    // Random phases: register settings from reset values to both extremes,
    // with every idling pattern.
    run_phase(RST_SETTLE_TIME, RST_LONG_THRESHOLD, RST_REPEAT_INTERVAL, RST_CLICK_GAP,
              0, 0, PHASE_POLLS, 1'b0);
    run_phase('0, 16'd1, 16'd1, 16'd1, 55, 0, PHASE_POLLS, 1'b0);
    run_phase('1, '1, '1, '1, 0, 55, PHASE_POLLS, 1'b0);
    run_phase('0, '0, '0, '0, 10, 10, PHASE_POLLS, 1'b0);
    run_phase(CFG_WIDTH'($urandom_range(0, 30)), CFG_WIDTH'($urandom_range(50, 600)),
              CFG_WIDTH'($urandom_range(5, 80)), CFG_WIDTH'($urandom_range(20, 300)),
              55, 0, PHASE_POLLS, 1'b0);
    // long receiver hold-off while the sender keeps offering
    run_phase(CFG_WIDTH'($urandom_range(0, 30)), CFG_WIDTH'($urandom_range(50, 600)),
              CFG_WIDTH'($urandom_range(5, 80)), CFG_WIDTH'($urandom_range(20, 300)),
              0, 55, PHASE_POLLS, 1'b1);
    run_phase(CFG_WIDTH'($urandom_range(0, 65535)), CFG_WIDTH'($urandom_range(0, 65535)),
              CFG_WIDTH'($urandom_range(0, 65535)), CFG_WIDTH'($urandom_range(0, 65535)),
              10, 10, PHASE_POLLS, 1'b0);

    saturate_counters();

    if (tracker.failures == 0 && tracker.outstanding() == 0)
      $display("CHECK OK");
    else
      $display("CHECK FAILED");
    $finish;
  end

endmodule
